[src/erm_pkg.sv]
// Shared constants and types for the Euler rotation matrix builder.
// No dependencies.
`default_nettype none
package erm_pkg;
   localparam int TableDepthDefault = 256;
   localparam int QueueDepth        = 2;
   localparam int AngleWidth        = 16;
   localparam int ValueWidth        = 16;
   localparam int FracBits          = 8;
   localparam int Q15Shift          = 15;
   localparam logic [AngleWidth-1:0] CosOffset = 16'h4000;
   localparam logic CmdWrite = 1'b0;
   localparam logic CmdBuild = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [7:0]             table_index;
      logic signed [15:0]     table_value;
      logic [15:0]            angle_x;
      logic [15:0]            angle_y;
      logic [15:0]            angle_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] row0_col0;
      logic signed [15:0] row0_col1;
      logic signed [15:0] row0_col2;
      logic signed [15:0] row1_col0;
      logic signed [15:0] row1_col1;
      logic signed [15:0] row1_col2;
      logic signed [15:0] row2_col0;
      logic signed [15:0] row2_col1;
      logic signed [15:0] row2_col2;
   } rsp_type;

   // Q15 multiply: floor shift by 15, wrap to 16 bits
   function automatic logic signed [15:0] qmul(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
      logic signed [31:0] p;
      p = a * b;
      return p[30:15];
   endfunction
endpackage
`default_nettype wire

[src/erm_if.sv]
// Valid/ready channel interfaces, each carrying one payload type.
// Depends on erm_pkg.
`default_nettype none
interface erm_req_if;
   logic              valid;
   logic              ready;
   erm_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface erm_rsp_if;
   logic              valid;
   logic              ready;
   erm_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/erm_front.sv]
// Front end: takes items and queues them, writes and builds in order.
// Depends on erm_pkg.
`default_nettype none
module erm_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire erm_pkg::req_type in_data,
   output logic      q_valid,
   input  wire logic q_pop,
   output erm_pkg::req_type q_item
);
   localparam int QDEPTH = erm_pkg::QueueDepth;
   localparam int QW = $clog2(QDEPTH);
   erm_pkg::req_type q_mem_ff [QDEPTH];
   logic [QW-1:0]  wp_ff, rp_ff;
   logic [QW:0]    cnt_ff;
   logic           push;

   // accept while the queue has room; table writes queue too so they stay in order
   assign in_ready = !reset && (cnt_ff != (QW+1)'(QDEPTH));
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = q_mem_ff[rp_ff];

   // hold queued items
   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == QW'(QDEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (q_pop) rp_ff <= (rp_ff == QW'(QDEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QW+1)'(push) - (QW+1)'(q_pop);
      end
   end
endmodule
`default_nettype wire

[src/erm_back.sv]
// Back end: sine table, interpolation and matrix assembly.
// Depends on erm_pkg.
`default_nettype none
module erm_back #(
   parameter int TABLE_DEPTH = erm_pkg::TableDepthDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   output logic      q_pop,
   input  wire erm_pkg::req_type q_item,
   output logic      out_valid,
   input  wire logic out_ready,
   output erm_pkg::rsp_type out_data
);
   localparam int AW = $clog2(TABLE_DEPTH);
   typedef enum logic [1:0] {IDLE, READ, MUL, DONE} state_type;

   logic [15:0] mem [TABLE_DEPTH];
   state_type   state_ff;
   logic [2:0]  step_ff;             // which of six angles
   logic [47:0] ang_ff;
   logic [15:0] cur_ff, nxt_ff;
   logic [7:0]  frac_ff;
   logic signed [15:0] v_ff [6];     // sx cx sy cy sz cz
   logic signed [15:0] t_ff [4];
   logic [1:0]  mstep_ff;
   logic        rd_pend_ff;
   logic        out_valid_ff;
   erm_pkg::rsp_type out_ff;
   logic        wr_en, pop_build, load_out;
   logic [AW-1:0] wr_addr;
   logic [15:0] a_sel, a_in;
   logic [AW-1:0] ra, rb;
   logic signed [16:0] diff;
   logic signed [24:0] prod;
   logic signed [15:0] interp;
   erm_pkg::rsp_type m_in;

   // angle for current step: x,x,y,y,z,z
   always_comb begin
      case (step_ff[2:1])
         2'd0:    a_sel = ang_ff[47:32];
         2'd1:    a_sel = ang_ff[31:16];
         default: a_sel = ang_ff[15:0];
      endcase
      a_in = step_ff[0] ? a_sel + erm_pkg::CosOffset : a_sel;
      ra   = a_in[15:8];
      rb   = ra + 1'b1;
      diff = $signed({nxt_ff[15], nxt_ff}) - $signed({cur_ff[15], cur_ff});
      prod = diff * $signed({1'b0, frac_ff});
      interp = $signed(cur_ff) + $signed(prod[23:8]);
   end

   assign q_pop     = (state_ff == IDLE) && q_valid;
   assign wr_en     = q_pop && (q_item.cmd == erm_pkg::CmdWrite);
   assign pop_build = q_pop && (q_item.cmd == erm_pkg::CmdBuild);
   assign wr_addr   = q_item.table_index[AW-1:0];
   assign load_out  = (state_ff == DONE) && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   // dual-port table: one write or two reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= q_item.table_value;
      end else begin
         cur_ff <= mem[ra];
         nxt_ff <= mem[rb];
      end
      frac_ff <= a_in[7:0];
   end

   always_comb begin
      m_in.row0_col0 = erm_pkg::qmul(t_ff[2], v_ff[0]) + t_ff[1];
      m_in.row0_col1 = erm_pkg::qmul(t_ff[0], v_ff[0]) - t_ff[3];
      m_in.row0_col2 = erm_pkg::qmul(v_ff[1], v_ff[2]);
      m_in.row1_col0 = erm_pkg::qmul(v_ff[1], v_ff[4]);
      m_in.row1_col1 = erm_pkg::qmul(v_ff[1], v_ff[5]);
      m_in.row1_col2 = -v_ff[0];
      m_in.row2_col0 = erm_pkg::qmul(t_ff[3], v_ff[0]) - t_ff[0];
      m_in.row2_col1 = erm_pkg::qmul(t_ff[1], v_ff[0]) + t_ff[2];
      m_in.row2_col2 = erm_pkg::qmul(v_ff[1], v_ff[3]);
   end

   // sequence: six table reads, four products, load of the result register
   always_ff @(posedge clock) begin
      if (pop_build) ang_ff <= {q_item.angle_x, q_item.angle_y, q_item.angle_z};
      if (rd_pend_ff) v_ff[step_ff - 3'd1] <= interp;
      if (state_ff == MUL) begin
         t_ff[mstep_ff] <= (mstep_ff == 2'd0) ? erm_pkg::qmul(v_ff[5], v_ff[2]) :
                           (mstep_ff == 2'd1) ? erm_pkg::qmul(v_ff[5], v_ff[3]) :
                           (mstep_ff == 2'd2) ? erm_pkg::qmul(v_ff[4], v_ff[2]) :
                                                erm_pkg::qmul(v_ff[4], v_ff[3]);
      end
      if (load_out) out_ff <= m_in;
      if (reset) begin
         state_ff <= IDLE; step_ff <= '0; mstep_ff <= '0; rd_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_out)       out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               step_ff <= '0; rd_pend_ff <= 1'b0; mstep_ff <= '0;
               if (pop_build) state_ff <= READ;
            end
            READ: begin
               rd_pend_ff <= (step_ff != 3'd6);
               step_ff <= step_ff + 1'b1;
               if (step_ff == 3'd6) state_ff <= MUL;
            end
            MUL: begin
               mstep_ff <= mstep_ff + 1'b1;
               if (mstep_ff == 2'd3) state_ff <= DONE;
            end
            DONE: begin
               if (load_out) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[src/euler_rotation_matrix_q15.sv]
// Top level of the Euler rotation matrix builder.
// Depends on erm_pkg, erm_if, erm_front, erm_back.
//  channel | dir | payload
//  req     | in  | cmd, table_index, table_value, angle_x/y/z
//  rsp     | out | nine Q15 matrix elements
// Every item passes a two-entry queue; the back end applies a table write as it
// pops it, in order with the builds around it. A build holds the back end for
// one pop, seven steps through the two-read table port, four products and one
// load of the result register, which waits while an earlier result is not taken.
// The result register lets the next item start while a result waits; req.ready
// drops only while the queue is full or reset is high.
// Reset is synchronous and clears control only; table is undefined until written.
`default_nettype none
module euler_rotation_matrix_q15 #(
   parameter int TABLE_DEPTH = erm_pkg::TableDepthDefault
) (
   input wire logic clock,
   input wire logic reset,
   erm_req_if.sink   req,
   erm_rsp_if.source rsp
);
   logic q_valid, q_pop;
   erm_pkg::req_type q_item;

   erm_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .q_valid, .q_pop, .q_item);

   erm_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.data)) else $error("result changed");
endmodule
`default_nettype wire
